// File: src/wcr_pkg.sv
// Shared types and constants of the wavetable cycle resampler.
package wcr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TABLE_SIZE  = 2048;
    localparam int T_BITS      = $clog2(TABLE_SIZE);
    localparam int IDX_W       = 11;

    localparam int A0_W = SAMPLE_BITS + 2;
    localparam int A1_W = SAMPLE_BITS + 3;
    localparam int A2_W = SAMPLE_BITS + 1;

    localparam int MA_W  = SAMPLE_BITS + 2 * T_BITS + 6;
    localparam int MB_W  = T_BITS + 1;
    localparam int PR_W  = MA_W + MB_W;
    localparam int CQ_W  = PR_W - 3 * T_BITS;
    localparam int RES_W = CQ_W + 1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

// File: src/wavetable_cycle_resampler.sv
// Top level of the wavetable cycle resampler: sample store, sequencer and arithmetic.
//
// An append request (opcode 0) stores one sample, unless the store is full and start_cycle
// is low, so appends stream at one per clock while no read is in progress. A read request
// (opcode 1) holds in_ready low until done: setup, then no tap for an empty cycle, one tap
// when the stored cycle is at least TABLE_SIZE long, two taps and one multiply for linear
// interpolation, or four taps and the cubic steps for cubic interpolation. The single-port
// sample memory delivers one tap per cycle, and the one shared multiplier is used three
// times in sequence for the cubic polynomial. A finished result waits in the output
// register, so the next request is taken while it is still pending. The
// store needs no clearing after reset: only entries below the current length are read.
module wavetable_cycle_resampler #(
    parameter int MAX_CYCLE_LEN = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic                                start_cycle,
    input  logic signed [wcr_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic [wcr_pkg::IDX_W-1:0]           out_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wcr_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic [wcr_pkg::IDX_W-1:0]           index_out,
    output logic                                last_of_cycle,
    output logic                                empty_cycle,
    output logic                                overflow_flag
);

    import wcr_pkg::*;

    localparam int LEN_W  = $clog2(MAX_CYCLE_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_CYCLE_LEN);
    localparam int CMP_W  = ((LEN_W > T_BITS) ? LEN_W : T_BITS) + 1;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CYCLE_LEN);

    localparam logic signed [PR_W-1:0] LIN_RND =
        {{(PR_W-T_BITS){1'b0}}, 1'b1, {(T_BITS-1){1'b0}}};
    localparam logic signed [PR_W-1:0] CUB_RND =
        {{(PR_W-3*T_BITS){1'b0}}, 1'b1, {(3*T_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_LAST,
        S_LIN_MUL,
        S_CUB_COEF,
        S_CUB_M1,
        S_CUB_A1,
        S_CUB_M2,
        S_CUB_A2,
        S_CUB_M3,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        M_EMPTY,
        M_DIRECT,
        M_LINEAR,
        M_CUBIC
    } mode_t;

    state_t                   state_reg;
    mode_t                    mode_reg;
    mode_t                    mode_next;
    logic [LEN_W-1:0]         len_reg;
    logic                     cubic_en_reg;
    logic                     out_valid_reg;
    logic                     rd_pend_reg;
    logic [1:0]               tap_reg;
    logic [1:0]               tap_last;
    logic [T_BITS-1:0]        idx_reg;
    logic [LEN_W-1:0]         base_reg;
    logic [LEN_W-1:0]         base_next;
    logic [T_BITS-1:0]        r_reg;
    sample_t                  y0_reg;
    sample_t                  y1_reg;
    sample_t                  y2_reg;
    sample_t                  y3_reg;
    logic signed [A0_W-1:0]   a0_reg;
    logic signed [A1_W-1:0]   a1_reg;
    logic signed [A2_W-1:0]   a2_reg;
    sample_t                  a3_reg;
    logic signed [MA_W-1:0]   acc_reg;
    logic signed [PR_W-1:0]   prod_reg;
    logic signed [PR_W-1:0]   prod_next;
    sample_t                  sample_out_reg;
    logic [IDX_W-1:0]         index_out_reg;
    logic                     last_reg;
    logic                     empty_reg;
    logic                     ovf_reg;

    logic                     append_acc;
    logic                     read_acc;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [SAMPLE_BITS-1:0]   ram_rdata;
    logic [LEN_W-1:0]         rd_sum;
    logic [LEN_W-1:0]         rd_addr;
    logic [LEN_W-1:0]         pos_p;
    logic [T_BITS-1:0]        pos_r;
    logic                     len_ge_table;
    logic                     cubic_fits;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [SAMPLE_BITS:0] lin_diff;
    logic signed [PR_W-1:0]   lin_rnd;
    logic signed [SAMPLE_BITS:0] lin_sum;
    logic signed [PR_W-1:0]   cub_rnd;
    logic signed [RES_W-1:0]  cub_sum;
    sample_t                  result;
    logic                     result_ovf;
    logic                     out_free;

    assign in_ready   = (state_reg == S_IDLE);
    assign append_acc = in_valid && in_ready && (opcode == OP_APPEND);
    assign read_acc   = in_valid && in_ready && (opcode == OP_READ);
    assign ram_we     = append_acc && (start_cycle || (len_reg != LEN_MAX));
    assign out_free   = !out_valid_reg || out_ready;

    assign rd_sum  = base_reg + LEN_W'(tap_reg);
    assign rd_addr = (rd_sum == len_reg) ? '0 : rd_sum;

    always_comb
    begin
        if (ram_we)
        begin
            ram_addr = start_cycle ? '0 : len_reg[ADDR_W-1:0];
        end
        else
        begin
            ram_addr = rd_addr[ADDR_W-1:0];
        end
    end

    wcr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_CYCLE_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_in),
        .rdata (ram_rdata)
    );

    assign pos_p        = prod_reg[T_BITS +: LEN_W];
    assign pos_r        = prod_reg[T_BITS-1:0];
    assign len_ge_table = CMP_W'(len_reg) >= CMP_W'(TABLE_SIZE);
    assign cubic_fits   = (pos_p != '0) && ((CMP_W'(pos_p) + CMP_W'(2)) < CMP_W'(len_reg));

    always_comb
    begin
        if (len_reg == '0)
        begin
            mode_next = M_EMPTY;
        end
        else if (len_ge_table)
        begin
            mode_next = M_DIRECT;
        end
        else if (cubic_en_reg && cubic_fits)
        begin
            mode_next = M_CUBIC;
        end
        else
        begin
            mode_next = M_LINEAR;
        end
        base_next = (mode_next == M_CUBIC) ? (pos_p - LEN_W'(1)) : pos_p;
    end

    always_comb
    begin
        unique case (mode_reg)
            M_CUBIC:  tap_last = 2'd3;
            M_LINEAR: tap_last = 2'd1;
            default:  tap_last = 2'd0;
        endcase
    end

    assign lin_diff = (SAMPLE_BITS+1)'(y3_reg) - (SAMPLE_BITS+1)'(y2_reg);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:    mul_a = signed'(MA_W'(len_reg));
            S_LIN_MUL: mul_a = MA_W'(lin_diff);
            S_CUB_M1:  mul_a = MA_W'(a0_reg);
            default:   mul_a = acc_reg;
        endcase
        if (state_reg == S_IDLE)
        begin
            mul_b = signed'({1'b0, out_index[T_BITS-1:0]});
        end
        else
        begin
            mul_b = signed'({1'b0, r_reg});
        end
    end

    assign prod_next = mul_a * mul_b;

    assign lin_rnd = prod_reg + LIN_RND;
    assign lin_sum = signed'(lin_rnd[T_BITS +: SAMPLE_BITS+1]) + (SAMPLE_BITS+1)'(y2_reg);
    assign cub_rnd = prod_reg + CUB_RND;
    assign cub_sum = RES_W'(signed'(cub_rnd[PR_W-1:3*T_BITS])) + RES_W'(a3_reg);

    always_comb
    begin
        result_ovf = 1'b0;
        unique case (mode_reg)
            M_EMPTY:  result = '0;
            M_DIRECT: result = y3_reg;
            M_LINEAR: result = lin_sum[SAMPLE_BITS-1:0];
            M_CUBIC:
            begin
                priority if (cub_sum > RES_W'(SAMPLE_MAX))
                begin
                    result     = SAMPLE_MAX;
                    result_ovf = 1'b1;
                end
                else if (cub_sum < RES_W'(SAMPLE_MIN))
                begin
                    result     = SAMPLE_MIN;
                    result_ovf = 1'b1;
                end
                else
                begin
                    result = cub_sum[SAMPLE_BITS-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_EMPTY;
            len_reg        <= '0;
            cubic_en_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
            tap_reg        <= '0;
            idx_reg        <= '0;
            base_reg       <= '0;
            r_reg          <= '0;
            y0_reg         <= '0;
            y1_reg         <= '0;
            y2_reg         <= '0;
            y3_reg         <= '0;
            a0_reg         <= '0;
            a1_reg         <= '0;
            a2_reg         <= '0;
            a3_reg         <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            sample_out_reg <= '0;
            index_out_reg  <= '0;
            last_reg       <= 1'b0;
            empty_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cubic_en_reg <= cfg_wr_data;
            end

            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            // shift returning taps in
            rd_pend_reg <= (state_reg == S_READ);
            if (rd_pend_reg)
            begin
                y0_reg <= y1_reg;
                y1_reg <= y2_reg;
                y2_reg <= y3_reg;
                y3_reg <= signed'(ram_rdata);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (append_acc)
                    begin
                        if (start_cycle)
                        begin
                            len_reg <= LEN_W'(1);
                        end
                        else if (len_reg != LEN_MAX)
                        begin
                            len_reg <= len_reg + LEN_W'(1);
                        end
                    end
                    if (read_acc)
                    begin
                        idx_reg   <= out_index[T_BITS-1:0];
                        prod_reg  <= prod_next;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    mode_reg <= mode_next;
                    base_reg <= base_next;
                    r_reg    <= pos_r;
                    tap_reg  <= '0;
                    if (mode_next == M_EMPTY)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (tap_reg == tap_last)
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 2'd1;
                    end
                end
                S_LAST:
                begin
                    unique case (mode_reg)
                        M_LINEAR: state_reg <= S_LIN_MUL;
                        M_CUBIC:  state_reg <= S_CUB_COEF;
                        default:  state_reg <= S_FINISH;
                    endcase
                end
                S_LIN_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_FINISH;
                end
                S_CUB_COEF:
                begin
                    a0_reg <= A0_W'(y3_reg) - A0_W'(y2_reg) - A0_W'(y0_reg) + A0_W'(y1_reg);
                    a1_reg <= (A1_W'(y0_reg) <<< 1) - (A1_W'(y1_reg) <<< 1)
                              + A1_W'(y2_reg) - A1_W'(y3_reg);
                    a2_reg <= A2_W'(y2_reg) - A2_W'(y0_reg);
                    a3_reg <= y1_reg;
                    state_reg <= S_CUB_M1;
                end
                S_CUB_M1:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_CUB_A1;
                end
                S_CUB_A1:
                begin
                    acc_reg   <= signed'(prod_reg[MA_W-1:0]) + (MA_W'(a1_reg) <<< T_BITS);
                    state_reg <= S_CUB_M2;
                end
                S_CUB_M2:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_CUB_A2;
                end
                S_CUB_A2:
                begin
                    acc_reg   <= signed'(prod_reg[MA_W-1:0]) + (MA_W'(a2_reg) <<< (2 * T_BITS));
                    state_reg <= S_CUB_M3;
                end
                S_CUB_M3:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        sample_out_reg <= result;
                        index_out_reg  <= IDX_W'(idx_reg);
                        last_reg       <= (IDX_W'(idx_reg) == IDX_LAST);
                        empty_reg      <= (mode_reg == M_EMPTY);
                        ovf_reg        <= result_ovf;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign index_out     = index_out_reg;
    assign last_of_cycle = last_reg;
    assign empty_cycle   = empty_reg;
    assign overflow_flag = ovf_reg;

endmodule

// File: src/wcr_ram.sv
// Generic single-port synchronous RAM with registered read.
module wcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/wcr_checker.sv
// Port-level checks of the wavetable cycle resampler, bound to the top level.
module wcr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_wr_en,
    input logic                                cfg_wr_data,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                opcode,
    input logic                                start_cycle,
    input logic signed [wcr_pkg::SAMPLE_BITS-1:0] sample_in,
    input logic [wcr_pkg::IDX_W-1:0]           out_index,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [wcr_pkg::SAMPLE_BITS-1:0] sample_out,
    input logic [wcr_pkg::IDX_W-1:0]           index_out,
    input logic                                last_of_cycle,
    input logic                                empty_cycle,
    input logic                                overflow_flag
);

    import wcr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(index_out))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_cycle |-> (sample_out == '0) && !overflow_flag)
        else $error("empty cycle result not zero");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_cycle == (index_out == IDX_LAST)))
        else $error("last_of_cycle does not match index");

    a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow_flag |-> (sample_out == SAMPLE_MAX) || (sample_out == SAMPLE_MIN))
        else $error("saturated result not at a rail");

endmodule

bind wavetable_cycle_resampler wcr_checker u_wcr_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the wavetable cycle resampler: predictor, stimulus and checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wcr_pkg::*;

    localparam int     MAX_CYCLE_LEN = 8192;
    localparam int     RANDOM_ITEMS  = 1450;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     CYCLE_LIMIT   = 2000000;
    localparam longint T1            = TABLE_SIZE;
    localparam longint T3            = T1 * T1 * T1;

    typedef struct {
        sample_t          sample;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             empty;
        logic             sat;
    } resample_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic             cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    logic             opcode;
    logic             start_cycle;
    sample_t          sample_in;
    logic [IDX_W-1:0] out_index;
    logic             out_valid;
    logic             out_ready;
    sample_t          sample_out;
    logic [IDX_W-1:0] index_out;
    logic             last_of_cycle;
    logic             empty_cycle;
    logic             overflow_flag;

    sample_t   cycle_mem [MAX_CYCLE_LEN];
    int        cycle_len;
    logic      cubic_on;
    resample_t resample_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int err_count;
    int cycle_count;
    int appends_sent;
    int reads_sent;
    int results_checked;
    int sat_expected;
    int empty_expected;

    wavetable_cycle_resampler #(
        .MAX_CYCLE_LEN(MAX_CYCLE_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .start_cycle  (start_cycle),
        .sample_in    (sample_in),
        .out_index    (out_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .index_out    (index_out),
        .last_of_cycle(last_of_cycle),
        .empty_cycle  (empty_cycle),
        .overflow_flag(overflow_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void store_sample(logic start, sample_t smp);
        if (start)
            cycle_len = 0;
        if (cycle_len < MAX_CYCLE_LEN)
        begin
            cycle_mem[cycle_len] = smp;
            cycle_len++;
        end
    endfunction

    function automatic resample_t resample_at(logic [IDX_W-1:0] idx);
        resample_t res;
        longint    pos, p, r, y0, y1, y2, y3, c0, c1, c2, acc;
        res.sample = '0;
        res.index  = idx;
        res.last   = (idx == IDX_LAST);
        res.empty  = 1'b0;
        res.sat    = 1'b0;
        if (cycle_len == 0)
        begin
            res.empty = 1'b1;
        end
        else
        begin
            pos = longint'(idx) * cycle_len;
            p   = pos / T1;
            r   = pos % T1;
            if (cycle_len >= TABLE_SIZE)
            begin
                res.sample = cycle_mem[p];
            end
            else if (cubic_on && p > 0 && p + 2 < cycle_len)
            begin
                y0  = cycle_mem[p - 1];
                y1  = cycle_mem[p];
                y2  = cycle_mem[p + 1];
                y3  = cycle_mem[p + 2];
                c0  = y3 - y2 - y0 + y1;
                c1  = y0 - y1 - c0;
                c2  = y2 - y0;
                // value * T^3, then round half up by one arithmetic shift
                acc = y1 * T3 + ((c0 * r + c1 * T1) * r + c2 * T1 * T1) * r;
                acc = (2 * acc + T3) >>> (3 * T_BITS + 1);
                if (acc > SAMPLE_MAX)
                begin
                    acc     = SAMPLE_MAX;
                    res.sat = 1'b1;
                end
                if (acc < SAMPLE_MIN)
                begin
                    acc     = SAMPLE_MIN;
                    res.sat = 1'b1;
                end
                res.sample = sample_t'(acc);
            end
            else
            begin
                y0  = cycle_mem[p];
                y1  = cycle_mem[(p + 1) % cycle_len];
                acc = y0 * (T1 - r) + y1 * r;
                acc = (2 * acc + T1) >>> (T_BITS + 1);
                res.sample = sample_t'(acc);
            end
        end
        return res;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return IDX_W'(1);
                2:       return IDX_LAST - IDX_W'(1);
                default: return IDX_LAST;
            endcase
        end
        return IDX_W'($urandom);
    endfunction

    task automatic report_error(string msg);
        err_count++;
        $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic send_request(logic op, logic start, sample_t smp, logic [IDX_W-1:0] idx);
        resample_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        start_cycle <= start;
        sample_in   <= smp;
        out_index   <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == OP_READ)
        begin
            want = resample_at(idx);
            resample_q.push_back(want);
            reads_sent++;
            if (want.sat)
                sat_expected++;
            if (want.empty)
                empty_expected++;
        end
        else
        begin
            store_sample(start, smp);
            appends_sent++;
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (resample_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_cubic(logic enable);
        drain_and_settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= enable;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cubic_on = enable;
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic load_cycle(int len);
        for (int i = 0; i < len; i++)
            send_request(OP_APPEND, i == 0, random_sample(), IDX_W'($urandom));
    endtask

    task automatic read_some(int n);
        send_request(OP_READ, 1'b0, sample_t'($urandom), IDX_LAST);
        send_request(OP_READ, 1'b0, sample_t'($urandom), '0);
        repeat (n)
            send_request(OP_READ, 1'($urandom), sample_t'($urandom), random_index());
    endtask

    task automatic test_empty_cycle();
        set_idle(0, 0);
        send_request(OP_READ, 1'b0, SAMPLE_MAX, '0);
        send_request(OP_READ, 1'b1, SAMPLE_MIN, IDX_LAST);
        send_request(OP_READ, 1'b0, '0, IDX_W'(1024));
    endtask

    task automatic test_short_cycle();
        set_cubic(1'b0);
        // one-sample cycle, then extend it
        send_request(OP_APPEND, 1'b1, sample_t'(-1), '0);
        send_request(OP_READ, 1'b0, '0, IDX_W'(1000));
        send_request(OP_APPEND, 1'b0, '0, IDX_LAST);
        send_request(OP_READ, 1'b0, '0, IDX_LAST);
        // overshoots high around tap 1, low around tap 3
        send_request(OP_APPEND, 1'b1, SAMPLE_MIN, '0);
        send_request(OP_APPEND, 1'b0, SAMPLE_MAX, '0);
        send_request(OP_APPEND, 1'b0, SAMPLE_MAX, '0);
        send_request(OP_APPEND, 1'b0, SAMPLE_MIN, '0);
        send_request(OP_APPEND, 1'b0, SAMPLE_MIN, '0);
        send_request(OP_APPEND, 1'b0, SAMPLE_MAX, '0);
        send_request(OP_READ, 1'b0, '0, '0);
        send_request(OP_READ, 1'b0, '0, IDX_W'(512));
        send_request(OP_READ, 1'b1, '0, IDX_W'(1195));
        send_request(OP_READ, 1'b0, '0, IDX_LAST);
        set_cubic(1'b1);
        send_request(OP_READ, 1'b0, '0, '0);
        send_request(OP_READ, 1'b0, '0, IDX_W'(512));
        send_request(OP_READ, 1'b1, '1, IDX_W'(1195));
        send_request(OP_READ, 1'b0, '0, IDX_W'(1700));
        send_request(OP_READ, 1'b0, '0, IDX_LAST);
    endtask

    task automatic test_long_cycle();
        set_cubic(1'b1);
        set_idle(0, 84);
        load_cycle(TABLE_SIZE - 1);
        read_some(16);
        load_cycle(TABLE_SIZE);
        read_some(16);
        set_cubic(1'b0);
        load_cycle(3001);
        read_some(16);
    endtask

    task automatic test_full_store();
        set_idle(23, 23);
        load_cycle(MAX_CYCLE_LEN);
        repeat (4)
            send_request(OP_APPEND, 1'b0, random_sample(), IDX_W'($urandom));
        read_some(12);
        // restart from a full store
        send_request(OP_APPEND, 1'b1, random_sample(), IDX_W'($urandom));
        read_some(3);
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        int pick;
        bit fresh;
        for (int phase = 0; phase < 8; phase++)
        begin
            set_cubic(phase[0]);
            case (phase >> 1)
                0:       set_idle(0, 0);
                1:       set_idle(84, 0);
                2:       set_idle(0, 84);
                default: set_idle(23, 23);
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 8)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    len = $urandom_range(12, 1);
                else if (pick < 97)
                    len = $urandom_range(48, 13);
                else
                    len = $urandom_range(200, 49);
                fresh = ($urandom_range(9) != 0);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        send_request(OP_READ, 1'($urandom), sample_t'($urandom), random_index());
                        sent++;
                    end
                    send_request(OP_APPEND, fresh && i == 0, random_sample(), IDX_W'($urandom));
                    sent++;
                end
                repeat ($urandom_range(24, 6))
                begin
                    send_request(OP_READ, $urandom_range(9) == 0, sample_t'($urandom),
                                 random_index());
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_results
        resample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (resample_q.size() == 0)
            begin
                report_error($sformatf("result for index %0d with none pending", index_out));
            end
            else
            begin
                want = resample_q.pop_front();
                results_checked++;
                if (sample_out !== want.sample)
                    report_error($sformatf("index %0d sample_out %0d, expected %0d",
                                           want.index, sample_out, want.sample));
                if (index_out !== want.index)
                    report_error($sformatf("index_out %0d, expected %0d", index_out, want.index));
                if (last_of_cycle !== want.last)
                    report_error($sformatf("index %0d last_of_cycle %b, expected %b",
                                           want.index, last_of_cycle, want.last));
                if (empty_cycle !== want.empty)
                    report_error($sformatf("index %0d empty_cycle %b, expected %b",
                                           want.index, empty_cycle, want.empty));
                if (overflow_flag !== want.sat)
                    report_error($sformatf("index %0d overflow_flag %b, expected %b",
                                           want.index, overflow_flag, want.sat));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: run stopped after %0d cycles, %0d results pending",
                 cycle_count, resample_q.size());
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_APPEND;
        start_cycle    = 1'b0;
        sample_in      = '0;
        out_index      = '0;
        cycle_len      = 0;
        cubic_on       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        appends_sent   = 0;
        reads_sent     = 0;
        results_checked = 0;
        sat_expected   = 0;
        empty_expected = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_cycle();
        test_short_cycle();
        test_long_cycle();
        test_full_store();
        test_random_traffic();
        drain_and_settle();
        $display("tb_top: %0d appends and %0d reads sent, %0d results checked",
                 appends_sent, reads_sent, results_checked);
        $display("tb_top: %0d saturated cubic and %0d empty-cycle results among them",
                 sat_expected, empty_expected);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
